// File: hdl/pdc_pkg.sv
// Shared constants, types and arithmetic helpers for the PID deadband-compensation core.
package pdc_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int EXT_WIDTH  = DATA_WIDTH + 16;
   localparam int ERR_WIDTH  = DATA_WIDTH + 1;
   localparam int INC_WIDTH  = DATA_WIDTH + 2;
   localparam int SUM_WIDTH  = EXT_WIDTH + 2;
   localparam int MUL_A_W    = EXT_WIDTH;
   localparam int MUL_B_W    = DATA_WIDTH + 2;
   localparam int DIGIT_W    = 16;
   localparam int MUL_DIGITS = 3;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int DIV_NUM_W  = 64;
   localparam int DIV_DEN_W  = 32;
   localparam int FIN_WIDTH  = DIV_NUM_W + 2;

   typedef enum logic [2:0] {
      CSR_PROP_GAIN,
      CSR_INTEG_GAIN,
      CSR_DERIV_POLE,
      CSR_DERIV_GAIN,
      CSR_LIMIT_LOW,
      CSR_LIMIT_HIGH,
      CSR_DB_LOW,
      CSR_DB_HIGH
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INT_GO,
      ST_INT_WAIT,
      ST_POLE_GO,
      ST_POLE_WAIT,
      ST_GAIN_GO,
      ST_GAIN_WAIT,
      ST_PROP_GO,
      ST_PROP_WAIT,
      ST_SUM,
      ST_DB_GO,
      ST_DB_WAIT,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] a_mag;
      logic [MUL_B_W-1:0] b_mag;
   } mul_req_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   function automatic logic [EXT_WIDTH-1:0] abs_ext(input logic signed [EXT_WIDTH-1:0] x);
      abs_ext = x[EXT_WIDTH-1] ? EXT_WIDTH'(-x) : EXT_WIDTH'(x);
   endfunction

   // round half away from zero after dropping the fraction, saturate to bits
   function automatic logic signed [EXT_WIDTH-1:0] rnd_sat(input logic [PROD_W-1:0] prod,
                                                           input logic neg,
                                                           input int bits);
      logic [PROD_W:0]           half;
      logic [PROD_W:0]           biased;
      logic [PROD_W-FRAC_BITS:0] r;
      logic [PROD_W-FRAC_BITS:0] lim;
      half = '0;
      half[FRAC_BITS-1] = 1'b1;
      biased = {1'b0, prod} + half;
      r = biased[PROD_W:FRAC_BITS];
      lim = '0;
      lim[bits-1] = 1'b1;
      if (!neg) begin
         lim = lim - 1'b1;
      end
      if (r > lim) begin
         r = lim;
      end
      if (neg) begin
         r = -r;
      end
      rnd_sat = $signed(r[EXT_WIDTH-1:0]);
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] clamp_lim(
         input logic signed [SUM_WIDTH-1:0] x,
         input logic [DATA_WIDTH-2:0] hi,
         input logic signed [DATA_WIDTH-1:0] lo);
      logic signed [SUM_WIDTH-1:0] hi_x;
      logic signed [SUM_WIDTH-1:0] lo_x;
      logic signed [SUM_WIDTH-1:0] m;
      hi_x = $signed(SUM_WIDTH'(hi));
      lo_x = SUM_WIDTH'(lo);
      m = (hi_x < x) ? hi_x : x;
      m = (m >= lo_x) ? m : lo_x;
      clamp_lim = m[DATA_WIDTH-1:0];
   endfunction

   function automatic logic signed [EXT_WIDTH-1:0] sat_ext(input logic signed [EXT_WIDTH:0] x);
      if (x[EXT_WIDTH] != x[EXT_WIDTH-1]) begin
         sat_ext = x[EXT_WIDTH] ? {1'b1, {(EXT_WIDTH-1){1'b0}}} : {1'b0, {(EXT_WIDTH-1){1'b1}}};
      end else begin
         sat_ext = x[EXT_WIDTH-1:0];
      end
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] sat_data(
         input logic signed [FIN_WIDTH-1:0] x);
      if (x[FIN_WIDTH-1:DATA_WIDTH-1] != {(FIN_WIDTH-DATA_WIDTH+1){x[FIN_WIDTH-1]}}) begin
         sat_data = x[FIN_WIDTH-1] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                                   : {1'b0, {(DATA_WIDTH-1){1'b1}}};
      end else begin
         sat_data = x[DATA_WIDTH-1:0];
      end
   endfunction

endpackage

// File: hdl/pid_controller_deadband_comp_core.sv
// PID controller with filtered derivative, anti-windup and deadband compensation: top level.
// A control step (command 0) keeps req_stall high, longer when the deadband map needs a
// division than when it does not and shorter with a zero integral gain, and longer still
// while the previous drive is still stalled in the output register; a reset command
// (command 1) does not raise req_stall. Up to five products run one after another through
// a single multiplier that takes 16 bits of its second operand per cycle, and the deadband
// scaling runs through a restoring divider that retires one quotient bit per cycle.
// req_stall is high from the accepted transaction until its drive is in the output
// register; a finished result waits in that register while the next transaction is
// already being worked on.
module pid_controller_deadband_comp_core import pdc_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_command,
   input  logic signed [DATA_WIDTH-1:0] req_desired,
   input  logic signed [DATA_WIDTH-1:0] req_measured,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_drive,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [2:0]                   csr_index,
   input  logic [DATA_WIDTH-1:0]        csr_data
);

   state_type state_ff, state_in;

   logic signed [DATA_WIDTH-1:0] prop_gain_ff, integ_gain_ff, deriv_gain_ff;
   logic [15:0]                  deriv_pole_ff;
   logic signed [DATA_WIDTH-1:0] limit_low_ff, db_low_ff;
   logic [DATA_WIDTH-2:0]        limit_high_ff, db_high_ff;

   logic signed [DATA_WIDTH-1:0] integ_ff, integ_in;
   logic signed [ERR_WIDTH-1:0]  prev_ff, prev_in;
   logic signed [EXT_WIDTH-1:0]  deriv_ff, deriv_in;

   logic signed [ERR_WIDTH-1:0]  err_ff, err_in;
   logic signed [EXT_WIDTH-1:0]  t1_ff, t1_in;
   logic signed [EXT_WIDTH-1:0]  p_ff, p_in;
   logic signed [DATA_WIDTH-1:0] u_ff, u_in;
   logic signed [DATA_WIDTH-1:0] res_ff, res_in;
   logic                         neg_ff, neg_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_WIDTH-1:0] rsp_drive_ff, rsp_drive_in;

   mul_req_type          mul_req;
   logic                 mul_done;
   logic [PROD_W-1:0]    mul_prod;
   div_req_type          div_req;
   logic                 div_done;
   logic [DIV_NUM_W-1:0] div_quo;

   logic                         req_take;
   logic                         out_free;
   logic                         op_neg;
   logic signed [ERR_WIDTH-1:0]  err_new;
   logic signed [INC_WIDTH-1:0]  err_sum;
   logic signed [INC_WIDTH-1:0]  err_dif;
   logic signed [ERR_WIDTH-1:0]  db_diff;
   logic [DIV_DEN_W-1:0]         den_mag;
   logic [EXT_WIDTH-1:0]         ki_mag, kd_mag, kp_mag, deriv_mag, u_mag;
   logic [EXT_WIDTH-1:0]         sum_mag, dif_mag, err_mag, db_mag;
   logic signed [EXT_WIDTH-1:0]  mul_val;
   logic signed [SUM_WIDTH-1:0]  pid_sum;
   logic signed [DATA_WIDTH-1:0] u_new;
   logic                         u_trivial;
   logic signed [DATA_WIDTH-1:0] u_trivial_val;
   logic signed [DATA_WIDTH-1:0] db_sel;
   logic [FIN_WIDTH-1:0]         q_ext;
   logic signed [FIN_WIDTH-1:0]  q_signed;

   pdc_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .mul_req  (mul_req),
      .mul_done (mul_done),
      .mul_prod (mul_prod)
   );

   pdc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .div_quo  (div_quo)
   );

   assign req_take = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   assign err_new = ERR_WIDTH'(req_desired) - ERR_WIDTH'(req_measured);
   assign err_sum = INC_WIDTH'(err_ff) + INC_WIDTH'(prev_ff);
   assign err_dif = INC_WIDTH'(err_ff) - INC_WIDTH'(prev_ff);

   assign db_diff = u_ff[DATA_WIDTH-1]
                  ? ERR_WIDTH'(limit_low_ff) - ERR_WIDTH'(db_low_ff)
                  : $signed(ERR_WIDTH'(limit_high_ff)) - $signed(ERR_WIDTH'(db_high_ff));
   assign den_mag = u_ff[DATA_WIDTH-1] ? DIV_DEN_W'(-limit_low_ff)
                                       : DIV_DEN_W'(limit_high_ff);

   assign ki_mag    = abs_ext(EXT_WIDTH'(integ_gain_ff));
   assign kd_mag    = abs_ext(EXT_WIDTH'(deriv_gain_ff));
   assign kp_mag    = abs_ext(EXT_WIDTH'(prop_gain_ff));
   assign deriv_mag = abs_ext(deriv_ff);
   assign u_mag     = abs_ext(EXT_WIDTH'(u_ff));
   assign sum_mag   = abs_ext(EXT_WIDTH'(err_sum));
   assign dif_mag   = abs_ext(EXT_WIDTH'(err_dif));
   assign err_mag   = abs_ext(EXT_WIDTH'(err_ff));
   assign db_mag    = abs_ext(EXT_WIDTH'(db_diff));

   assign mul_val = rnd_sat(mul_prod, neg_ff, (state_ff == ST_INT_WAIT) ? INC_WIDTH : EXT_WIDTH);

   assign pid_sum = SUM_WIDTH'(p_ff) + SUM_WIDTH'(integ_ff) + SUM_WIDTH'(deriv_ff);
   assign u_new   = clamp_lim(pid_sum, limit_high_ff, limit_low_ff);

   always_comb begin
      u_trivial     = 1'b0;
      u_trivial_val = '0;
      if (u_new == '0) begin
         u_trivial = 1'b1;
      end else if (!u_new[DATA_WIDTH-1]) begin
         if (limit_high_ff == '0) begin
            u_trivial     = 1'b1;
            u_trivial_val = $signed({1'b0, db_high_ff});
         end
      end else if (!limit_low_ff[DATA_WIDTH-1]) begin
         u_trivial     = 1'b1;
         u_trivial_val = db_low_ff;
      end
   end

   assign db_sel   = u_ff[DATA_WIDTH-1] ? db_low_ff : $signed({1'b0, db_high_ff});
   assign q_ext    = FIN_WIDTH'(div_quo);
   assign q_signed = neg_ff ? $signed(-q_ext) : $signed(q_ext);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && !req_command) begin
               state_in = (integ_gain_ff != '0) ? ST_INT_GO : ST_POLE_GO;
            end
         end
         ST_INT_GO:    state_in = ST_INT_WAIT;
         ST_INT_WAIT:  if (mul_done) state_in = ST_POLE_GO;
         ST_POLE_GO:   state_in = ST_POLE_WAIT;
         ST_POLE_WAIT: if (mul_done) state_in = ST_GAIN_GO;
         ST_GAIN_GO:   state_in = ST_GAIN_WAIT;
         ST_GAIN_WAIT: if (mul_done) state_in = ST_PROP_GO;
         ST_PROP_GO:   state_in = ST_PROP_WAIT;
         ST_PROP_WAIT: if (mul_done) state_in = ST_SUM;
         ST_SUM:       state_in = u_trivial ? ST_FINISH : ST_DB_GO;
         ST_DB_GO:     state_in = ST_DB_WAIT;
         ST_DB_WAIT:   if (mul_done) state_in = ST_DIV_GO;
         ST_DIV_GO:    state_in = ST_DIV_WAIT;
         ST_DIV_WAIT:  if (div_done) state_in = ST_FINISH;
         ST_FINISH:    if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // unit requests
   always_comb begin
      req_stall     = (state_ff != ST_IDLE);
      mul_req.start = 1'b0;
      mul_req.a_mag = '0;
      mul_req.b_mag = '0;
      op_neg        = 1'b0;
      div_req.start = (state_ff == ST_DIV_GO);
      div_req.num   = mul_prod[DIV_NUM_W-1:0];
      div_req.den   = den_mag;
      case (state_ff)
         ST_INT_GO: begin
            mul_req.start = 1'b1;
            mul_req.a_mag = ki_mag;
            mul_req.b_mag = sum_mag[MUL_B_W-1:0];
            op_neg        = integ_gain_ff[DATA_WIDTH-1] ^ err_sum[INC_WIDTH-1];
         end
         ST_POLE_GO: begin
            mul_req.start = 1'b1;
            mul_req.a_mag = deriv_mag;
            mul_req.b_mag = MUL_B_W'(deriv_pole_ff);
            op_neg        = deriv_ff[EXT_WIDTH-1];
         end
         ST_GAIN_GO: begin
            mul_req.start = 1'b1;
            mul_req.a_mag = kd_mag;
            mul_req.b_mag = dif_mag[MUL_B_W-1:0];
            op_neg        = deriv_gain_ff[DATA_WIDTH-1] ^ err_dif[INC_WIDTH-1];
         end
         ST_PROP_GO: begin
            mul_req.start = 1'b1;
            mul_req.a_mag = kp_mag;
            mul_req.b_mag = err_mag[MUL_B_W-1:0];
            op_neg        = prop_gain_ff[DATA_WIDTH-1] ^ err_ff[ERR_WIDTH-1];
         end
         ST_DB_GO: begin
            mul_req.start = 1'b1;
            mul_req.a_mag = u_mag;
            mul_req.b_mag = db_mag[MUL_B_W-1:0];
            op_neg        = db_diff[ERR_WIDTH-1];
         end
         default: begin
            op_neg = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      integ_in     = integ_ff;
      prev_in      = prev_ff;
      deriv_in     = deriv_ff;
      err_in       = err_ff;
      t1_in        = t1_ff;
      p_in         = p_ff;
      u_in         = u_ff;
      res_in       = res_ff;
      neg_in       = mul_req.start ? op_neg : neg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_drive_in = rsp_drive_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               err_in = err_new;
               if (req_command) begin
                  integ_in = '0;
                  deriv_in = '0;
                  prev_in  = err_new;
               end
            end
         end
         ST_INT_WAIT: begin
            if (mul_done) begin
               integ_in = clamp_lim(SUM_WIDTH'(integ_ff) + SUM_WIDTH'(mul_val),
                                    limit_high_ff, limit_low_ff);
            end
         end
         ST_POLE_WAIT: begin
            if (mul_done) t1_in = mul_val;
         end
         ST_GAIN_WAIT: begin
            if (mul_done) deriv_in = sat_ext((EXT_WIDTH+1)'(t1_ff) + (EXT_WIDTH+1)'(mul_val));
         end
         ST_PROP_WAIT: begin
            if (mul_done) p_in = mul_val;
         end
         ST_SUM: begin
            u_in    = u_new;
            prev_in = err_ff;
            res_in  = u_trivial_val;
         end
         ST_DIV_WAIT: begin
            if (div_done) res_in = sat_data(FIN_WIDTH'(db_sel) + q_signed);
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_drive_in = res_ff;
            end
         end
         default: begin
            res_in = res_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         integ_ff      <= '0;
         prev_ff       <= '0;
         deriv_ff      <= '0;
         prop_gain_ff  <= '0;
         integ_gain_ff <= '0;
         deriv_pole_ff <= '0;
         deriv_gain_ff <= '0;
         limit_low_ff  <= '0;
         limit_high_ff <= '0;
         db_low_ff     <= '0;
         db_high_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         integ_ff     <= integ_in;
         prev_ff      <= prev_in;
         deriv_ff     <= deriv_in;
         if (csr_valid && csr_ready) begin
            case (csr_idx_type'(csr_index))
               CSR_PROP_GAIN:  prop_gain_ff  <= $signed(csr_data);
               CSR_INTEG_GAIN: integ_gain_ff <= $signed(csr_data);
               CSR_DERIV_POLE: deriv_pole_ff <= csr_data[15:0];
               CSR_DERIV_GAIN: deriv_gain_ff <= $signed(csr_data);
               CSR_LIMIT_LOW:  limit_low_ff  <= $signed(csr_data);
               CSR_LIMIT_HIGH: limit_high_ff <= csr_data[DATA_WIDTH-2:0];
               CSR_DB_LOW:     db_low_ff     <= $signed(csr_data);
               CSR_DB_HIGH:    db_high_ff    <= csr_data[DATA_WIDTH-2:0];
               default:        db_high_ff    <= db_high_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      err_ff       <= err_in;
      t1_ff        <= t1_in;
      p_ff         <= p_in;
      u_ff         <= u_in;
      res_ff       <= res_in;
      neg_ff       <= neg_in;
      rsp_drive_ff <= rsp_drive_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

endmodule

// File: hdl/pdc_mul.sv
// Shared unsigned multiplier, one 16-bit digit of the second operand per cycle.
module pdc_mul import pdc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  mul_req_type       mul_req,
   output logic              mul_done,
   output logic [PROD_W-1:0] mul_prod
);

   localparam int B_PAD = DIGIT_W * MUL_DIGITS;

   logic [MUL_A_W-1:0] a_ff, a_in;
   logic [B_PAD-1:0]   b_ff, b_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [PROD_W-1:0]  acc_ff, acc_in;
   logic [DIGIT_W-1:0] digit;
   logic [MUL_A_W+DIGIT_W-1:0] pp;

   assign digit = b_ff[cnt_ff*DIGIT_W +: DIGIT_W];
   assign pp    = a_ff * digit;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      acc_in  = acc_ff;
      if (mul_req.start) begin
         a_in    = mul_req.a_mag;
         b_in    = B_PAD'(mul_req.b_mag);
         cnt_in  = 2'(MUL_DIGITS - 1);
         busy_in = 1'b1;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = (acc_ff << DIGIT_W) + PROD_W'(pp);
         if (cnt_ff == 2'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
   end

   assign mul_done = done_ff;
   assign mul_prod = acc_ff;

endmodule

// File: hdl/pdc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module pdc_div import pdc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  div_req_type          div_req,
   output logic                 div_done,
   output logic [DIV_NUM_W-1:0] div_quo
);

   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   shifted;
   logic [DIV_DEN_W:0]   diff;
   logic                 fits;

   assign shifted = {rem_ff, num_ff[DIV_NUM_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         num_in  = div_req.num;
         den_in  = div_req.den;
         rem_in  = '0;
         cnt_in  = 6'(DIV_NUM_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
         num_in = {num_ff[DIV_NUM_W-2:0], fits};
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign div_done = done_ff;
   assign div_quo  = num_ff;

endmodule

// File: hdl/pdc_checker.sv
// Port-level assertions for the PID deadband-compensation core, bound to the top level.
module pdc_checker import pdc_pkg::*; (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         req_command,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic signed [DATA_WIDTH-1:0] rsp_drive
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_drive))
      else $error("stalled transaction changed");

   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_command |=> req_stall)
      else $error("control step did not hold the input side");

   a_reset_cmd_free: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_command |=> !req_stall)
      else $error("reset command left the input side stalled");

   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result present right after reset");

endmodule

bind pid_controller_deadband_comp_core pdc_checker u_pdc_checker (.*);
